### sv/hsvu_pkg.sv
// Shared types and constants for the Hadamard state vector update block.
package hsvu_pkg;

	// Default sizing
	localparam int MAX_QUBITS = 16;
	localparam int AMP_WIDTH  = 32;

	// Fixed field widths of the stream payload and the qubit count
	localparam int TARGET_W = 4;
	localparam int INDEX_W  = 16;
	localparam int DATA_W   = 32;
	localparam int NQ_W     = 5;

	// 1/sqrt2 in Q1.31, rounded to nearest
	localparam logic signed [31:0] INV_ROOT2_Q31 = 32'sd1518500250;

	// Operation codes
	localparam logic [1:0] MODE_GATE  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;
	localparam logic [1:0] MODE_INIT  = 2'd3;

	// Classified command passed from front to back
	typedef struct packed {
		logic [1:0]          mode;
		logic                err;
		logic [TARGET_W-1:0] target;
		logic [NQ_W-1:0]     nq;
		logic [INDEX_W-1:0]  idx;
		logic [DATA_W-1:0]   re;
		logic [DATA_W-1:0]   im;
	} cmd_t;

endpackage

### sv/hsvu_front.sv
// Front end: holds the qubit count register, accepts and classifies items.
module hsvu_front #(
	parameter int MAX_QUBITS = hsvu_pkg::MAX_QUBITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hsvu_pkg::NQ_W-1:0]    cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [87:0]                  s_tdata,
	input  logic [1:0]                   s_tuser,
	output logic                         push_valid,
	input  logic                         push_ready,
	output hsvu_pkg::cmd_t               push_cmd
);

	logic [hsvu_pkg::NQ_W-1:0]     qubits_q;
	logic [hsvu_pkg::NQ_W-1:0]     nq;
	logic [hsvu_pkg::TARGET_W-1:0] target;
	logic [hsvu_pkg::INDEX_W-1:0]  idx;
	logic                          idx_bad;

	function automatic logic [hsvu_pkg::NQ_W-1:0] NQ_W_EXT(
			input logic [hsvu_pkg::TARGET_W-1:0] t);
		NQ_W_EXT = hsvu_pkg::NQ_W'(t);
	endfunction

	// Qubit count register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qubits_q <= hsvu_pkg::NQ_W'(16);
		end else if (cfg_valid) begin
			qubits_q <= cfg_data;
		end
	end

	// Clamp the count into 1..MAX_QUBITS
	always_comb begin
		if (qubits_q == '0) begin
			nq = hsvu_pkg::NQ_W'(1);
		end else if (qubits_q > hsvu_pkg::NQ_W'(MAX_QUBITS)) begin
			nq = hsvu_pkg::NQ_W'(MAX_QUBITS);
		end else begin
			nq = qubits_q;
		end
	end

	assign target  = s_tdata[3:0];
	assign idx     = s_tdata[19:4];
	assign idx_bad = ((32'(idx) >> nq) != 32'd0);

	// Classify the transaction
	always_comb begin
		push_cmd        = '0;
		push_cmd.mode   = s_tuser;
		push_cmd.target = target;
		push_cmd.nq     = nq;
		push_cmd.idx    = idx;
		push_cmd.re     = s_tdata[51:20];
		push_cmd.im     = s_tdata[83:52];
		unique case (s_tuser) inside
			hsvu_pkg::MODE_GATE: push_cmd.err = (NQ_W_EXT(target) >= nq);
			hsvu_pkg::MODE_READ, hsvu_pkg::MODE_WRITE: push_cmd.err = idx_bad;
			default: push_cmd.err = 1'b0;
		endcase
	end

	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;

endmodule

### sv/hsvu_queue.sv
// Two-entry command queue between front and back.
module hsvu_queue #(
	parameter int W = $bits(hsvu_pkg::cmd_t)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [W-1:0] slot_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = slot_q[rd_q];

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### sv/hsvu_back.sv
// Back end: two-bank amplitude store, pair sweep pipeline and result register.
module hsvu_back #(
	parameter int MAX_QUBITS = hsvu_pkg::MAX_QUBITS,
	parameter int AMP_WIDTH  = hsvu_pkg::AMP_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  hsvu_pkg::cmd_t cmd,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [63:0]    m_tdata,
	output logic           m_tuser
);

	localparam int MQ  = MAX_QUBITS;
	localparam int AW  = AMP_WIDTH;
	localparam int BA  = (MQ > 1) ? MQ - 1 : 1;
	localparam int DEP = 1 << BA;
	localparam int PW  = AW + 33;
	localparam logic signed [PW-1:0] PMAX = (PW'(1) <<< (AW - 1)) - PW'(1);
	localparam logic signed [PW-1:0] PMIN = -PMAX - PW'(1);
	localparam logic signed [31:0]   DMAX = 32'((64'(1) << (AW - 1)) - 64'(1));
	localparam logic signed [31:0]   DMIN = -DMAX - 32'sd1;
	localparam logic [AW-1:0]        ONE  = AW'(1) << (AW - 2);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_INIT  = 3'd4;
	localparam logic [2:0] ST_RD    = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]           state_q;
	hsvu_pkg::cmd_t       cmd_q;
	logic [BA-1:0]        cnt_q;
	logic [BA-1:0]        last;
	logic [MQ:0]          lastw;
	logic [31:0]          res_re_q;
	logic [31:0]          res_im_q;
	logic                 res_err_q;
	logic                 out_v_q;
	logic [63:0]          out_d_q;
	logic                 out_e_q;
	logic                 load;

	// Banked store: index parity picks the bank, upper bits the row
	logic [2*AW-1:0] mem0 [DEP];
	logic [2*AW-1:0] mem1 [DEP];
	logic [2*AW-1:0] rd0_q;
	logic [2*AW-1:0] rd1_q;
	logic [BA-1:0]   ra0;
	logic [BA-1:0]   ra1;
	logic            we0;
	logic            we1;
	logic [BA-1:0]   wa0;
	logic [BA-1:0]   wa1;
	logic [2*AW-1:0] wd0;
	logic [2*AW-1:0] wd1;

	// Pair indices for the current count
	logic [MQ-1:0] pe;
	logic [MQ-1:0] tmask;
	logic [MQ-1:0] low;
	logic [MQ-1:0] i0;
	logic [MQ-1:0] i1;
	logic [MQ-1:0] ridx;
	logic          issue;

	// Pipeline
	logic                 v_s1;
	logic [MQ-1:0]        i0_s1;
	logic [MQ-1:0]        i1_s1;
	logic                 sw_s1;
	logic [2*AW-1:0]      a;
	logic [2*AW-1:0]      b;
	logic                 v_s2;
	logic [MQ-1:0]        i0_s2;
	logic [MQ-1:0]        i1_s2;
	logic signed [AW:0]   sre_s2;
	logic signed [AW:0]   sim_s2;
	logic signed [AW:0]   dre_s2;
	logic signed [AW:0]   dim_s2;
	logic                 v_s3;
	logic [MQ-1:0]        i0_s3;
	logic [MQ-1:0]        i1_s3;
	logic signed [PW-1:0] pre_s3;
	logic signed [PW-1:0] pim_s3;
	logic signed [PW-1:0] qre_s3;
	logic signed [PW-1:0] qim_s3;

	// Write ports before bank routing
	logic            wa_v;
	logic [MQ-1:0]   wa_idx;
	logic [2*AW-1:0] wa_dat;
	logic            wb_v;
	logic [MQ-1:0]   wb_idx;
	logic [2*AW-1:0] wb_dat;

	logic [AW-1:0]   sel_re;
	logic [AW-1:0]   sel_im;
	logic [2*AW-1:0] sel;

	function automatic logic [AW-1:0] scale(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] x;
		x = (p + (PW'(1) <<< 30)) >>> 31;
		if (x > PMAX) begin
			scale = PMAX[AW-1:0];
		end else if (x < PMIN) begin
			scale = PMIN[AW-1:0];
		end else begin
			scale = x[AW-1:0];
		end
	endfunction

	function automatic logic [AW-1:0] sat_in(input logic signed [31:0] v);
		if (v > DMAX) begin
			sat_in = DMAX[AW-1:0];
		end else if (v < DMIN) begin
			sat_in = DMIN[AW-1:0];
		end else begin
			sat_in = v[AW-1:0];
		end
	endfunction

	function automatic logic [BA-1:0] row(input logic [MQ-1:0] i);
		row = BA'(i >> 1);
	endfunction

	// Index of the pair under the counter
	always_comb begin
		pe    = MQ'(cnt_q);
		tmask = MQ'(1) << cmd_q.target;
		low   = tmask - MQ'(1);
		i0    = (pe & low) | ((pe & ~low) << 1);
		i1    = i0 | tmask;
		ridx  = MQ'(cmd_q.idx);
		lastw = ((MQ + 1)'(1) << (cmd_q.nq - hsvu_pkg::NQ_W'(1))) - (MQ + 1)'(1);
		last  = BA'(lastw);
		issue = (state_q == ST_SWEEP);
	end

	// Read address routing
	always_comb begin
		if (issue) begin
			ra0 = (^i0) ? row(i1) : row(i0);
			ra1 = (^i0) ? row(i0) : row(i1);
		end else begin
			ra0 = row(ridx);
			ra1 = row(ridx);
		end
	end

	// Store access
	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[wa0] <= wd0;
		end
		rd0_q <= mem0[ra0];
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			mem1[wa1] <= wd1;
		end
		rd1_q <= mem1[ra1];
	end

	// Order the pair read from the banks: a holds the amplitude at i0, b the one at i1
	always_comb begin
		a = sw_s1 ? rd1_q : rd0_q;
		b = sw_s1 ? rd0_q : rd1_q;
	end

	// Pipeline registers
	always_ff @(posedge clk) begin
		i0_s1  <= i0;
		i1_s1  <= i1;
		sw_s1  <= ^i0;
		i0_s2  <= i0_s1;
		i1_s2  <= i1_s1;
		sre_s2 <= (AW + 1)'($signed(a[AW-1:0])) + (AW + 1)'($signed(b[AW-1:0]));
		sim_s2 <= (AW + 1)'($signed(a[2*AW-1:AW])) + (AW + 1)'($signed(b[2*AW-1:AW]));
		dre_s2 <= (AW + 1)'($signed(a[AW-1:0])) - (AW + 1)'($signed(b[AW-1:0]));
		dim_s2 <= (AW + 1)'($signed(a[2*AW-1:AW])) - (AW + 1)'($signed(b[2*AW-1:AW]));
		i0_s3  <= i0_s2;
		i1_s3  <= i1_s2;
		pre_s3 <= sre_s2 * hsvu_pkg::INV_ROOT2_Q31;
		pim_s3 <= sim_s2 * hsvu_pkg::INV_ROOT2_Q31;
		qre_s3 <= dre_s2 * hsvu_pkg::INV_ROOT2_Q31;
		qim_s3 <= dim_s2 * hsvu_pkg::INV_ROOT2_Q31;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Write sources: sweep write-back, initialize, single write
	always_comb begin
		wa_v   = 1'b0;
		wa_idx = '0;
		wa_dat = '0;
		wb_v   = 1'b0;
		wb_idx = '0;
		wb_dat = '0;
		if (v_s3) begin
			wa_v   = 1'b1;
			wa_idx = i0_s3;
			wa_dat = {scale(pim_s3), scale(pre_s3)};
			wb_v   = 1'b1;
			wb_idx = i1_s3;
			wb_dat = {scale(qim_s3), scale(qre_s3)};
		end else if (state_q == ST_INIT) begin
			wa_v   = 1'b1;
			wa_idx = MQ'(pe << 1);
			wa_dat = (cnt_q == '0) ? {{AW{1'b0}}, ONE} : '0;
			wb_v   = (MQ > 1);
			wb_idx = MQ'(pe << 1) | MQ'(1);
			wb_dat = '0;
		end else if (state_q == ST_EXEC && !cmd_q.err && cmd_q.mode == hsvu_pkg::MODE_WRITE) begin
			wa_v   = 1'b1;
			wa_idx = ridx;
			wa_dat = {sat_in(cmd_q.im), sat_in(cmd_q.re)};
		end
	end

	// Route write ports to banks
	always_comb begin
		we0 = (wa_v && !(^wa_idx)) || (wb_v && !(^wb_idx));
		we1 = (wa_v && (^wa_idx)) || (wb_v && (^wb_idx));
		wa0 = (wa_v && !(^wa_idx)) ? row(wa_idx) : row(wb_idx);
		wd0 = (wa_v && !(^wa_idx)) ? wa_dat : wb_dat;
		wa1 = (wa_v && (^wa_idx)) ? row(wa_idx) : row(wb_idx);
		wd1 = (wa_v && (^wa_idx)) ? wa_dat : wb_dat;
	end

	// Read result selection
	always_comb begin
		sel    = (^ridx) ? rd1_q : rd0_q;
		sel_re = sel[AW-1:0];
		sel_im = sel[2*AW-1:AW];
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign load      = (state_q == ST_DONE) && (!out_v_q || m_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			cmd_q     <= '0;
			res_re_q  <= '0;
			res_im_q  <= '0;
			res_err_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cnt_q     <= '0;
					res_re_q  <= '0;
					res_im_q  <= '0;
					res_err_q <= cmd_q.err;
					if (cmd_q.err) begin
						state_q <= ST_DONE;
					end else begin
						unique case (cmd_q.mode)
							hsvu_pkg::MODE_GATE:  state_q <= ST_SWEEP;
							hsvu_pkg::MODE_READ:  state_q <= ST_RD;
							hsvu_pkg::MODE_WRITE: state_q <= ST_DONE;
							default:              state_q <= ST_INIT;
						endcase
					end
				end
				ST_SWEEP: begin
					if (cnt_q == last) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + BA'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_DONE;
					end
				end
				ST_INIT: begin
					if (cnt_q == last) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + BA'(1);
					end
				end
				ST_RD: begin
					res_re_q <= 32'($signed(sel_re));
					res_im_q <= 32'($signed(sel_im));
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_d_q <= {res_im_q, res_re_q};
			out_e_q <= res_err_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tuser  = out_e_q;

endmodule

### sv/hadamard_state_vector_update.sv
// Top level of the Hadamard state vector update block.
//
// Usage: items arrive on the s_ stream (mode in s_tuser), results leave on the
// m_ stream, one result per item. The cfg channel writes the qubit count n;
// write it only while the block is idle. Modes: Hadamard gate on a target
// qubit, read one amplitude, write one amplitude, initialize to basis zero.
// Items run one at a time; the gate sweep moves one amplitude pair per cycle
// through a four-stage read / add / scale / write-back pipeline over a
// two-bank store. A two-entry queue behind the front end takes new items
// while the back end works or a result waits.
// Reset clears control state and sets n to 16; the store holds no value until
// written or initialized. When the receiver stalls, the result holds in the
// output register and the back end waits before loading the next one.
module hadamard_state_vector_update #(
	parameter int MAX_QUBITS = hsvu_pkg::MAX_QUBITS,
	parameter int AMP_WIDTH  = hsvu_pkg::AMP_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,   // qubits_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	// target_qubit[3:0], amp_index[19:4], real_in[51:20], imag_in[83:52]
	input  logic [87:0] s_tdata,
	input  logic [1:0]  s_tuser,    // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // real_out[31:0], imag_out[63:32]
	output logic        m_tuser     // error
);

	hsvu_pkg::cmd_t push_cmd;
	hsvu_pkg::cmd_t pop_cmd;
	logic           push_valid;
	logic           push_ready;
	logic           pop_valid;
	logic           pop_ready;

	hsvu_front #(
		.MAX_QUBITS(MAX_QUBITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	hsvu_queue #(
		.W($bits(hsvu_pkg::cmd_t))
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push_valid),
		.in_ready (push_ready),
		.in_data  (push_cmd),
		.out_valid(pop_valid),
		.out_ready(pop_ready),
		.out_data (pop_cmd)
	);

	hsvu_back #(
		.MAX_QUBITS(MAX_QUBITS),
		.AMP_WIDTH (AMP_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(pop_valid),
		.cmd_ready(pop_ready),
		.cmd      (pop_cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
